### rtl/acop_pkg.sv
// Shared types and constants for the colour organ with gain control.
// Holds the configuration register set, its index codes and reset values.
// No dependencies.
package acop_pkg;

  // Field widths fixed by the interface
  localparam int LEVEL_W = 10;
  localparam int GAIN_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 18;
  localparam int NUM_BANDS = 3;

  // Default averaging window length in beats
  localparam int WINDOW_LEN_DEF = 200;

  // Gain control constants
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 10'sd80;
  localparam logic signed [GAIN_W-1:0] GAIN_STEP  = 10'sd4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_MAX       = 3'd0,
    CFG_GAIN_MIN       = 3'd1,
    CFG_TARGET_LEVEL   = 3'd2,
    CFG_PWM_FULL_SCALE = 3'd3,
    CFG_HIGH_THRESHOLD = 3'd4,
    CFG_MID_THRESHOLD  = 3'd5,
    CFG_LOW_THRESHOLD  = 3'd6,
    CFG_FADE_PERIOD    = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [BYTE_W-1:0]  RST_GAIN_MAX       = 8'd250;
  localparam logic [BYTE_W-1:0]  RST_GAIN_MIN       = 8'd5;
  localparam logic [LEVEL_W-1:0] RST_TARGET_LEVEL   = 10'd200;
  localparam logic [BYTE_W-1:0]  RST_PWM_FULL_SCALE = 8'd31;
  localparam logic [LEVEL_W-1:0] RST_THRESHOLD      = 10'd600;
  localparam logic [BYTE_W-1:0]  RST_FADE_PERIOD    = 8'd30;

  // Full configuration register set
  typedef struct packed {
    logic [BYTE_W-1:0]  gain_max;
    logic [BYTE_W-1:0]  gain_min;
    logic [LEVEL_W-1:0] target_level;
    logic [BYTE_W-1:0]  pwm_full_scale;
    logic [LEVEL_W-1:0] high_threshold;
    logic [LEVEL_W-1:0] mid_threshold;
    logic [LEVEL_W-1:0] low_threshold;
    logic [BYTE_W-1:0]  fade_period;
  } cfg_t;

endpackage

### rtl/acop_agc.sv
// Automatic gain control: windowed sum of main level and gain update.
// Depends on acop_pkg.
module acop_agc #(
  parameter int WINDOW_LEN = acop_pkg::WINDOW_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [acop_pkg::LEVEL_W-1:0]   main_band,
  input  acop_pkg::cfg_t                 cfg,
  output logic [acop_pkg::BYTE_W-1:0]    gain_out,
  output logic                           gain_changed
);

  localparam logic [acop_pkg::BYTE_W-1:0] WIN_LEN_B = acop_pkg::BYTE_W'(WINDOW_LEN);
  localparam logic [acop_pkg::SUM_W:0]    WIN_LEN_S = (acop_pkg::SUM_W + 1)'(WINDOW_LEN);

  logic [acop_pkg::BYTE_W-1:0]         win_cnt_r, win_cnt_nxt, win_inc;
  logic [acop_pkg::SUM_W-1:0]          sum_r, sum_nxt, sum_add;
  logic signed [acop_pkg::GAIN_W-1:0]  gain_r, gain_nxt, gain_adj, lim_lo, lim_hi;
  logic [acop_pkg::SUM_W:0]            bound_lo, bound_hi;
  logic                                win_end, avg_lt, avg_gt;

  // Window count and running sum
  always_comb begin
    win_inc = win_cnt_r + 8'd1;
    sum_add = sum_r + acop_pkg::SUM_W'(main_band);
    win_end = (win_inc == WIN_LEN_B);
    win_cnt_nxt = win_end ? '0 : win_inc;
    sum_nxt     = win_end ? '0 : sum_add;
  end

  // Average versus target without a divider:
  // floor(sum/W) < tgt  <=>  sum < tgt*W ; floor(sum/W) > tgt  <=>  sum >= tgt*W + W
  always_comb begin
    bound_lo = (acop_pkg::SUM_W + 1)'(cfg.target_level) * WIN_LEN_S;
    bound_hi = bound_lo + WIN_LEN_S;
    avg_lt   = ({1'b0, sum_add} < bound_lo);
    avg_gt   = ({1'b0, sum_add} >= bound_hi);
  end

  // Gain step inside the limits, snap back outside them
  always_comb begin
    lim_lo = signed'({2'b00, cfg.gain_min});
    lim_hi = signed'({2'b00, cfg.gain_max});
    gain_adj = gain_r;
    if (gain_r >= lim_lo && gain_r <= lim_hi) begin
      if (avg_lt) begin
        gain_adj = gain_r + acop_pkg::GAIN_STEP;
      end else if (avg_gt) begin
        gain_adj = gain_r - acop_pkg::GAIN_STEP;
      end
    end else begin
      if (gain_adj < lim_lo) begin
        gain_adj = lim_lo + 10'sd1;
      end
      if (gain_adj > lim_hi) begin
        gain_adj = lim_hi - 10'sd1;
      end
    end
    gain_nxt = win_end ? gain_adj : gain_r;
  end

  // Clamp to byte range for the result
  always_comb begin
    if (gain_nxt < 10'sd0) begin
      gain_out = '0;
    end else if (gain_nxt > 10'sd255) begin
      gain_out = 8'd255;
    end else begin
      gain_out = gain_nxt[acop_pkg::BYTE_W-1:0];
    end
    gain_changed = win_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= '0;
      sum_r     <= '0;
      gain_r    <= acop_pkg::GAIN_RESET;
    end else if (step) begin
      win_cnt_r <= win_cnt_nxt;
      sum_r     <= sum_nxt;
      gain_r    <= gain_nxt;
    end
  end

endmodule

### rtl/acop_band.sv
// Band display: brightness per band, fade and PWM counters, output drive.
// Depends on acop_pkg.
module acop_band (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           step,
  input  logic [acop_pkg::NUM_BANDS-1:0][acop_pkg::LEVEL_W-1:0] level,
  input  acop_pkg::cfg_t                                 cfg,
  output logic [acop_pkg::NUM_BANDS-1:0]                 band_on
);

  logic [acop_pkg::BYTE_W-1:0] bright_r [acop_pkg::NUM_BANDS];
  logic [acop_pkg::BYTE_W-1:0] bright_nxt [acop_pkg::NUM_BANDS];
  logic [acop_pkg::LEVEL_W-1:0] thr [acop_pkg::NUM_BANDS];
  logic [acop_pkg::BYTE_W-1:0] pwm_r, pwm_nxt, fade_r, fade_nxt;
  logic [acop_pkg::BYTE_W:0]   pwm_inc, fade_inc;

  // Thresholds in band order: high, mid, low
  always_comb begin
    thr[0] = cfg.high_threshold;
    thr[1] = cfg.mid_threshold;
    thr[2] = cfg.low_threshold;
  end

  // Per-band fade, trigger and PWM compare
  always_comb begin
    for (int i = 0; i < acop_pkg::NUM_BANDS; i++) begin
      bright_nxt[i] = bright_r[i];
      if (fade_r == '0 && bright_r[i] != '0) begin
        bright_nxt[i] = bright_r[i] - 8'd1;
      end
      if (level[i] > thr[i]) begin
        bright_nxt[i] = cfg.pwm_full_scale;
      end
      band_on[i] = (bright_nxt[i] > pwm_r);
    end
  end

  // Counters wrap once they pass their top
  always_comb begin
    pwm_inc  = {1'b0, pwm_r} + 9'd1;
    fade_inc = {1'b0, fade_r} + 9'd1;
    pwm_nxt  = (pwm_inc > {1'b0, cfg.pwm_full_scale}) ? '0 : pwm_inc[acop_pkg::BYTE_W-1:0];
    fade_nxt = (fade_inc > {1'b0, cfg.fade_period}) ? '0 : fade_inc[acop_pkg::BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < acop_pkg::NUM_BANDS; i++) begin
        bright_r[i] <= '0;
      end
      pwm_r  <= '0;
      fade_r <= '0;
    end else if (step) begin
      for (int i = 0; i < acop_pkg::NUM_BANDS; i++) begin
        bright_r[i] <= bright_nxt[i];
      end
      pwm_r  <= pwm_nxt;
      fade_r <= fade_nxt;
    end
  end

endmodule

### rtl/agc_colour_organ_pwm_core.sv
// Colour organ with automatic gain control and PWM band drive.
//
// Input stream: one beat carries a set of four 10-bit levels (high, mid,
// low band and main). Output stream: one beat per input beat with the three
// band drive bits and the current gain; tuser flags a beat whose gain was
// just recomputed at the end of an averaging window of WINDOW_LEN beats.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), to be
// used only while no beats are in flight.
//
// A beat accepted into the input register is processed by single-pass
// logic and moves into the result register when that register is free.
// Throughput is one beat per cycle while the receiver does not stall: the
// input register feeds single-pass logic into the result register.
// When the receiver stalls the result register holds; an empty input
// register still takes one beat, and once both registers are full in_tready
// stays low until the output moves.
// Reset (rst_n low, synchronous) empties both registers, sets gain to 80,
// clears counters and brightness, and loads register defaults.
module agc_colour_organ_pwm_core #(
  parameter int WINDOW_LEN = acop_pkg::WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: high_band[9:0], mid_band[19:10], low_band[29:20], main_band[39:30]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: high_on[0], mid_on[1], low_on[2], gain_out[10:3], zero[15:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // out_tuser: gain_changed[0]
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  acop_pkg::cfg_t cfg_r;

  logic        in_valid_r;
  logic [39:0] in_data_r;
  logic        out_valid_r;
  logic [2:0]  out_on_r;
  logic [7:0]  out_gain_r;
  logic        out_chg_r;
  logic        advance;

  logic [acop_pkg::NUM_BANDS-1:0][acop_pkg::LEVEL_W-1:0] levels;
  logic [acop_pkg::NUM_BANDS-1:0] band_on;
  logic [7:0]  gain_val;
  logic        gain_chg;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_max       <= acop_pkg::RST_GAIN_MAX;
      cfg_r.gain_min       <= acop_pkg::RST_GAIN_MIN;
      cfg_r.target_level   <= acop_pkg::RST_TARGET_LEVEL;
      cfg_r.pwm_full_scale <= acop_pkg::RST_PWM_FULL_SCALE;
      cfg_r.high_threshold <= acop_pkg::RST_THRESHOLD;
      cfg_r.mid_threshold  <= acop_pkg::RST_THRESHOLD;
      cfg_r.low_threshold  <= acop_pkg::RST_THRESHOLD;
      cfg_r.fade_period    <= acop_pkg::RST_FADE_PERIOD;
    end else if (cfg_we) begin
      unique case (acop_pkg::cfg_idx_t'(cfg_index))
        acop_pkg::CFG_GAIN_MAX:       cfg_r.gain_max       <= cfg_wdata[7:0];
        acop_pkg::CFG_GAIN_MIN:       cfg_r.gain_min       <= cfg_wdata[7:0];
        acop_pkg::CFG_TARGET_LEVEL:   cfg_r.target_level   <= cfg_wdata;
        acop_pkg::CFG_PWM_FULL_SCALE: cfg_r.pwm_full_scale <= cfg_wdata[7:0];
        acop_pkg::CFG_HIGH_THRESHOLD: cfg_r.high_threshold <= cfg_wdata;
        acop_pkg::CFG_MID_THRESHOLD:  cfg_r.mid_threshold  <= cfg_wdata;
        acop_pkg::CFG_LOW_THRESHOLD:  cfg_r.low_threshold  <= cfg_wdata;
        acop_pkg::CFG_FADE_PERIOD:    cfg_r.fade_period    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: the held beat moves on when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
  end

  assign levels[0] = in_data_r[9:0];
  assign levels[1] = in_data_r[19:10];
  assign levels[2] = in_data_r[29:20];

  acop_agc #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_agc (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .main_band    (in_data_r[39:30]),
    .cfg          (cfg_r),
    .gain_out     (gain_val),
    .gain_changed (gain_chg)
  );

  acop_band u_band (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .level   (levels),
    .cfg     (cfg_r),
    .band_on (band_on)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_on_r   <= band_on;
      out_gain_r <= gain_val;
      out_chg_r  <= gain_chg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_gain_r, out_on_r};
  assign out_tuser  = out_chg_r;

endmodule
